>>> design/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers for the cache tag block
// no dependencies; the assertion bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on each rising edge, off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on each rising edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> design/sactr_pkg.sv
// sactr_pkg: constants, codes and types of the set associative cache tag block
// used by sactr_cfg, sactr_ctrl and the top level
package sactr_pkg;

  localparam int unsigned MAX_LINES_DEF  = 1024;
  localparam int unsigned ADDR_WIDTH_DEF = 32;

  localparam int unsigned AGE_W    = 10;
  localparam logic [AGE_W-1:0] AGE_MAX = 10'd1023;
  localparam int unsigned LFSR_W   = 16;
  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;
  localparam int unsigned VICTIM_W = 32;
  localparam int unsigned GEO_W    = 5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINES_LOG2   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORGANIZATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED  = 3'd4;

  // organization codes
  localparam logic [1:0] ORG_DIRECT   = 2'd0;
  localparam logic [1:0] ORG_FOUR_WAY = 2'd1;

  // replacement policy codes
  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;

  typedef struct packed {
    logic [GEO_W-1:0] offset_bits;
    logic [GEO_W-1:0] set_bits;
    logic [GEO_W-1:0] way_bits;
    logic [1:0]       policy;
  } geom_t;

  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
  } meta_t;

  // galois step, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] r;
    r = v >> 1;
    if (v[0]) begin
      r = r ^ LFSR_MASK;
    end
    return r;
  endfunction

endpackage

>>> design/sactr_ram.sv
// sactr_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module sactr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/sactr_cfg.sv
// sactr_cfg: configuration registers, cache geometry decode and the replacement lfsr
// depends on sactr_pkg
module sactr_cfg
  import sactr_pkg::*;
#(
  parameter int unsigned MAX_LINES = MAX_LINES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  lfsr_step,
  output logic [LFSR_W-1:0]     lfsr_next,
  output geom_t                 geom
);

  localparam int unsigned LB = $clog2(MAX_LINES);
  localparam logic [GEO_W-1:0] LB_V = GEO_W'(LB);

  logic [4:0]        offset_bits;
  logic [3:0]        lines_log2;
  logic [1:0]        organization;
  logic [1:0]        policy;
  logic [LFSR_W-1:0] lfsr;

  logic [GEO_W-1:0] lines_eff;

  assign cfg_ready = 1'b1;
  assign lfsr_next = lfsr_advance(lfsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits  <= 5'd0;
      lines_log2   <= 4'd10;
      organization <= ORG_DIRECT;
      policy       <= POL_FIFO;
      lfsr         <= LFSR_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET_BITS:  offset_bits  <= cfg_data[4:0];
        REG_LINES_LOG2:   lines_log2   <= cfg_data[3:0];
        REG_ORGANIZATION: organization <= cfg_data[1:0];
        REG_POLICY:       policy       <= cfg_data[1:0];
        REG_RANDOM_SEED:  lfsr <= (cfg_data == '0) ? LFSR_W'(1) : cfg_data[LFSR_W-1:0];
        default: ;
      endcase
    end else if (lfsr_step) begin
      lfsr <= lfsr_next;
    end
  end

  always_comb begin
    // line count is capped at the physical depth
    lines_eff = (GEO_W'(lines_log2) > LB_V) ? LB_V : GEO_W'(lines_log2);
    geom.offset_bits = GEO_W'(offset_bits);
    geom.policy      = policy;
    case (organization)
      ORG_DIRECT: begin
        geom.set_bits = lines_eff;
        geom.way_bits = '0;
      end
      ORG_FOUR_WAY: begin
        geom.way_bits = (lines_eff > GEO_W'(2)) ? GEO_W'(2) : lines_eff;
        geom.set_bits = lines_eff - geom.way_bits;
      end
      default: begin
        geom.set_bits = '0;
        geom.way_bits = lines_eff;
      end
    endcase
  end

endmodule

>>> design/sactr_ctrl.sv
// sactr_ctrl: sequencer that walks the ways of one set through the shared tag compare
// depends on sactr_pkg and assert_macros.svh; drives the line, tag and fifo rams
`include "assert_macros.svh"
module sactr_ctrl
  import sactr_pkg::*;
#(
  parameter int unsigned MAX_LINES  = MAX_LINES_DEF,
  parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF,
  localparam int unsigned LB = $clog2(MAX_LINES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ADDR_WIDTH-1:0] address,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic                  res_hit,
  output logic                  res_evicted,
  output logic [VICTIM_W-1:0]   res_victim,
  input  geom_t                 geom,
  input  logic [LFSR_W-1:0]     lfsr_next,
  output logic                  lfsr_step,
  output logic [LB-1:0]         line_raddr,
  output logic [LB-1:0]         line_waddr,
  output logic                  meta_we,
  output meta_t                 meta_wdata,
  input  meta_t                 meta_rdata,
  output logic                  tag_we,
  output logic [ADDR_WIDTH-1:0] tag_wdata,
  input  logic [ADDR_WIDTH-1:0] tag_rdata,
  output logic                  fifo_we,
  output logic [LB-1:0]         fifo_waddr,
  output logic [LB-1:0]         fifo_wdata,
  output logic [LB-1:0]         fifo_raddr,
  input  logic [LB-1:0]         fifo_rdata
);

  localparam int unsigned CW = LB + 1;
  localparam int unsigned EXT_W = (ADDR_WIDTH > LB) ? ADDR_WIDTH : LB;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SEARCH = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_PEEK   = 7'b0010000,
    S_TOUCH  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  logic [LB-1:0]         clr_cnt;
  logic [CW-1:0]         icnt;
  logic                  pvalid;
  logic [LB-1:0]         pw;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [LB-1:0]         idx_q;
  logic [LB-1:0]         base_q;
  logic [LB-1:0]         wmask_q;
  logic [GEO_W-1:0]      way_bits_q;
  logic [1:0]            policy_q;
  logic                  hit_q;
  logic [LB-1:0]         hit_way;
  logic [AGE_W-1:0]      hit_age;
  logic                  inv_q;
  logic [LB-1:0]         inv_way;
  logic [AGE_W-1:0]      best_age;
  logic [LB-1:0]         lru_way;
  logic [LB-1:0]         tw;
  logic [AGE_W-1:0]      old_age;
  logic                  repl_q;
  logic [VICTIM_W-1:0]   victim_q;

  // address split
  logic [GEO_W:0]        shift_c;
  logic [ADDR_WIDTH-1:0] tag_c;
  logic [EXT_W-1:0]      addr_sh;
  logic [CW-1:0]         set_full;
  logic [CW-1:0]         way_full;
  logic [LB-1:0]         idx_c;
  logic [LB-1:0]         base_c;

  logic [CW-1:0]         ways_cnt;
  logic                  issue;
  logic                  match;
  logic [LB-1:0]         fifo_m;
  logic [31:0]           lfsr_ext;
  logic [LB-1:0]         tw_c;

  assign s_tready  = (state == S_IDLE);
  assign tag_wdata = tag_q;
  assign fifo_raddr = idx_q;

  always_comb begin
    shift_c  = {1'b0, geom.offset_bits} + {1'b0, geom.set_bits};
    tag_c    = address >> shift_c;
    addr_sh  = EXT_W'(address) >> geom.offset_bits;
    set_full = (CW'(1) << geom.set_bits) - CW'(1);
    way_full = (CW'(1) << geom.way_bits) - CW'(1);
    idx_c    = addr_sh[LB-1:0] & set_full[LB-1:0];
    base_c   = idx_c << geom.way_bits;
  end

  assign ways_cnt = CW'(1) << way_bits_q;
  assign issue    = (icnt < ways_cnt);
  assign match    = meta_rdata.valid && (tag_rdata == tag_q);
  assign fifo_m   = fifo_rdata & wmask_q;
  assign lfsr_ext = 32'(lfsr_next);

  always_comb begin
    line_raddr = base_q + icnt[LB-1:0];
    line_waddr = base_q + pw;
    meta_we    = 1'b0;
    meta_wdata = '0;
    tag_we     = 1'b0;
    fifo_we    = 1'b0;
    fifo_waddr = idx_q;
    fifo_wdata = '0;
    lfsr_step  = 1'b0;
    tw_c       = '0;
    case (state)
      S_CLEAR: begin
        line_waddr = clr_cnt;
        meta_we    = 1'b1;
        fifo_we    = 1'b1;
        fifo_waddr = clr_cnt;
      end
      S_DECIDE: begin
        if (hit_q) begin
          tw_c = hit_way;
        end else if (inv_q) begin
          tw_c       = inv_way;
          fifo_we    = 1'b1;
          fifo_wdata = (fifo_rdata + LB'(1)) & wmask_q;
        end else if (way_bits_q == '0) begin
          tw_c = '0;
        end else begin
          case (policy_q)
            POL_FIFO: begin
              tw_c       = fifo_m;
              fifo_we    = 1'b1;
              fifo_wdata = (fifo_m + LB'(1)) & wmask_q;
            end
            POL_LRU: tw_c = lru_way;
            default: begin
              lfsr_step = 1'b1;
              tw_c      = lfsr_ext[LB-1:0] & wmask_q;
            end
          endcase
        end
        // fetch the victim's tag and age
        line_raddr = base_q + tw_c;
      end
      S_TOUCH: begin
        if (pvalid) begin
          if (pw == tw) begin
            meta_we          = 1'b1;
            meta_wdata.valid = 1'b1;
            meta_wdata.age   = '0;
            tag_we           = !hit_q;
          end else if (meta_rdata.valid && (meta_rdata.age < old_age) &&
                       (meta_rdata.age < AGE_MAX)) begin
            meta_we          = 1'b1;
            meta_wdata.valid = 1'b1;
            meta_wdata.age   = meta_rdata.age + AGE_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      icnt     <= '0;
      pvalid   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // a new result loaded in S_DONE takes the place of the one leaving
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + LB'(1);
          if (&clr_cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            tag_q      <= tag_c;
            idx_q      <= idx_c;
            base_q     <= base_c;
            wmask_q    <= way_full[LB-1:0];
            way_bits_q <= geom.way_bits;
            policy_q   <= geom.policy;
            hit_q      <= 1'b0;
            inv_q      <= 1'b0;
            best_age   <= '0;
            lru_way    <= '0;
            icnt       <= '0;
            pvalid     <= 1'b0;
            state      <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (issue) begin
            icnt <= icnt + CW'(1);
            pw   <= icnt[LB-1:0];
          end
          pvalid <= issue;
          if (pvalid) begin
            if (match) begin
              hit_q   <= 1'b1;
              hit_way <= pw;
              hit_age <= meta_rdata.age;
              state   <= S_DECIDE;
            end else begin
              if (!meta_rdata.valid && !inv_q) begin
                inv_q   <= 1'b1;
                inv_way <= pw;
              end
              if (meta_rdata.age > best_age) begin
                best_age <= meta_rdata.age;
                lru_way  <= pw;
              end
              if (pw == wmask_q) begin
                state <= S_DECIDE;
              end
            end
          end
        end
        S_DECIDE: begin
          tw      <= tw_c;
          old_age <= hit_q ? hit_age : AGE_MAX;
          repl_q  <= !hit_q && !inv_q;
          icnt    <= '0;
          pvalid  <= 1'b0;
          state   <= (hit_q || inv_q) ? S_TOUCH : S_PEEK;
        end
        S_PEEK: begin
          old_age  <= meta_rdata.age;
          victim_q <= VICTIM_W'(tag_rdata);
          state    <= S_TOUCH;
        end
        S_TOUCH: begin
          if (issue) begin
            icnt <= icnt + CW'(1);
            pw   <= icnt[LB-1:0];
          end
          pvalid <= issue;
          if (pvalid && (pw == wmask_q)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            res_hit     <= hit_q;
            res_evicted <= repl_q;
            res_victim  <= repl_q ? victim_q : '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK_ALWAYS(a_reset_clears, clk, rst |=> (state == S_CLEAR), "reset did not start the clearing sweep")
  `ASSERT_CLK(a_search_read_only, clk, rst, (state == S_SEARCH) |-> !meta_we && !tag_we && !fifo_we, "ram written during tag search")
  `ASSERT_CLK(a_fifo_once, clk, rst, fifo_we && (state == S_DECIDE) |=> !fifo_we, "fifo pointer written twice")
  `ASSERT_CLK(a_touch_in_set, clk, rst, meta_we && (state == S_TOUCH) |-> ((line_waddr & ~wmask_q) == base_q), "age update outside the set")
  `ASSERT_CLK(a_victim_zero, clk, rst, m_tvalid && !res_evicted |-> (res_victim == '0) && (state != S_CLEAR), "victim tag without eviction")

endmodule

>>> design/set_assoc_cache_tag_replacement_top.sv
// set_assoc_cache_tag_replacement_top: cache tag lookup and replacement block
// depends on sactr_pkg, sactr_cfg, sactr_ctrl and sactr_ram
//
//  group   dir  signals                     beat carries
//  s_*     in   tvalid tready tdata         one byte address
//  m_*     out  tvalid tready tdata tuser   hit, eviction flag, victim tag
//  cfg_*   in   valid ready index data      one register write
//
// an item walks its set twice, one way per cycle through the line ram read port:
// a search pass over the ways, then an age update pass; a replacement adds a peek at
// the victim's tag and age, and a hit ends the search pass early
// after reset the line and fifo rams are cleared, s_tready low
// a result waits in the output register; the next item is taken meanwhile but its
// result is held back until m_tready frees the register
module set_assoc_cache_tag_replacement_top
  import sactr_pkg::*;
#(
  parameter int unsigned MAX_LINES  = MAX_LINES_DEF,
  parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF,
  localparam int unsigned IN_W = ((ADDR_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // address, zero padded
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [VICTIM_W-1:0]   m_tdata,   // victim_tag
  output logic [1:0]            m_tuser,   // hit, evicted
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned LB = $clog2(MAX_LINES);

  geom_t                 geom;
  logic [LFSR_W-1:0]     lfsr_next;
  logic                  lfsr_step;
  logic                  res_hit;
  logic                  res_evicted;
  logic [VICTIM_W-1:0]   res_victim;
  logic [LB-1:0]         line_raddr;
  logic [LB-1:0]         line_waddr;
  logic                  meta_we;
  meta_t                 meta_wdata;
  meta_t                 meta_rdata;
  logic                  tag_we;
  logic [ADDR_WIDTH-1:0] tag_wdata;
  logic [ADDR_WIDTH-1:0] tag_rdata;
  logic                  fifo_we;
  logic [LB-1:0]         fifo_waddr;
  logic [LB-1:0]         fifo_wdata;
  logic [LB-1:0]         fifo_raddr;
  logic [LB-1:0]         fifo_rdata;

  assign m_tdata = res_victim;
  assign m_tuser = {res_evicted, res_hit};

  sactr_cfg #(
    .MAX_LINES(MAX_LINES)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .lfsr_step(lfsr_step),
    .lfsr_next(lfsr_next),
    .geom     (geom)
  );

  sactr_ctrl #(
    .MAX_LINES (MAX_LINES),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .address    (s_tdata[ADDR_WIDTH-1:0]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .res_hit    (res_hit),
    .res_evicted(res_evicted),
    .res_victim (res_victim),
    .geom       (geom),
    .lfsr_next  (lfsr_next),
    .lfsr_step  (lfsr_step),
    .line_raddr (line_raddr),
    .line_waddr (line_waddr),
    .meta_we    (meta_we),
    .meta_wdata (meta_wdata),
    .meta_rdata (meta_rdata),
    .tag_we     (tag_we),
    .tag_wdata  (tag_wdata),
    .tag_rdata  (tag_rdata),
    .fifo_we    (fifo_we),
    .fifo_waddr (fifo_waddr),
    .fifo_wdata (fifo_wdata),
    .fifo_raddr (fifo_raddr),
    .fifo_rdata (fifo_rdata)
  );

  // valid mark and recency age per line
  sactr_ram #(
    .WIDTH($bits(meta_t)),
    .DEPTH(MAX_LINES)
  ) u_meta_ram (
    .clk  (clk),
    .we   (meta_we),
    .waddr(line_waddr),
    .wdata(meta_wdata),
    .raddr(line_raddr),
    .rdata(meta_rdata)
  );

  sactr_ram #(
    .WIDTH(ADDR_WIDTH),
    .DEPTH(MAX_LINES)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr(line_waddr),
    .wdata(tag_wdata),
    .raddr(line_raddr),
    .rdata(tag_rdata)
  );

  // fifo pointer per set
  sactr_ram #(
    .WIDTH(LB),
    .DEPTH(MAX_LINES)
  ) u_fifo_ram (
    .clk  (clk),
    .we   (fifo_we),
    .waddr(fifo_waddr),
    .wdata(fifo_wdata),
    .raddr(fifo_raddr),
    .rdata(fifo_rdata)
  );

endmodule

>>> bench/set_assoc_cache_tag_replacement_top_tb.sv
// set_assoc_cache_tag_replacement_top_tb: self-checking bench for the cache tag block
// a behavioral tag/valid/age model predicts hit, eviction and victim tag per address beat
// depends on sactr_pkg and set_assoc_cache_tag_replacement_top
`timescale 1ns / 100ps

module set_assoc_cache_tag_replacement_top_tb;
  import sactr_pkg::*;

  localparam int unsigned LINES = MAX_LINES_DEF;

  // codes the package leaves unnamed
  localparam logic [1:0] ORG_FULL       = 2'd2;
  localparam logic [1:0] ORG_ALT_FULL   = 2'd3;
  localparam logic [1:0] POL_RANDOM     = 2'd2;
  localparam logic [1:0] POL_ALT_RANDOM = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    bit          hit;
    bit          evicted;
    logic [31:0] victim;
  } lookup_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;   // address
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [VICTIM_W-1:0]   m_tdata;        // victim_tag
  logic [1:0]            m_tuser;        // hit, evicted
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  set_assoc_cache_tag_replacement_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [4:0]  cur_offset_bits;
  logic [3:0]  cur_lines_log2;
  logic [1:0]  cur_org;
  logic [1:0]  cur_policy;
  logic [31:0] line_tag [LINES];
  bit          line_valid [LINES];
  int unsigned line_age [LINES];
  int unsigned set_fifo_ptr [LINES];
  logic [15:0] lfsr_state;

  lookup_result_t pending_lookups [$];
  logic [31:0]    addr_pool [$];
  int             fail_count = 0;
  int unsigned    burst_left = 0;
  int             hold_req = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  function automatic void cache_shape(output int unsigned ways, output int unsigned sets,
                                      output int unsigned ibits);
    int unsigned lines;
    lines = 1 << cur_lines_log2;
    if (lines > LINES) lines = LINES;
    if (cur_org == ORG_DIRECT) begin
      ways = 1;
      sets = lines;
    end else if (cur_org == ORG_FOUR_WAY) begin
      ways = (lines < 4) ? lines : 4;
      sets = lines / ways;
    end else begin
      ways = lines;
      sets = 1;
    end
    ibits = $clog2(sets);
  endfunction

  // way w becomes most recent, valid ways younger than it age by one
  function automatic void mark_recent(int unsigned base, int unsigned ways, int unsigned w);
    int unsigned prev;
    prev = line_age[base + w];
    for (int unsigned i = 0; i < ways; i++) begin
      if (i != w && line_valid[base + i] && line_age[base + i] < prev &&
          line_age[base + i] < AGE_MAX) begin
        line_age[base + i]++;
      end
    end
    line_age[base + w] = 0;
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [31:0] addr);
    lookup_result_t r;
    int unsigned ways, sets, ibits, shift, idx, base, w, best;
    logic [31:0] tag;
    bit lsb;
    cache_shape(ways, sets, ibits);
    shift = cur_offset_bits + ibits;
    tag = (shift >= 32) ? 32'd0 : (addr >> shift);
    idx = (addr >> cur_offset_bits) & (sets - 1);
    base = idx * ways;
    r.hit = 1'b0;
    r.evicted = 1'b0;
    r.victim = '0;
    for (w = 0; w < ways; w++) begin
      if (line_valid[base + w] && line_tag[base + w] == tag) begin
        mark_recent(base, ways, w);
        r.hit = 1'b1;
        return r;
      end
    end
    for (w = 0; w < ways; w++) begin
      if (!line_valid[base + w]) begin
        line_tag[base + w] = tag;
        line_age[base + w] = AGE_MAX;
        line_valid[base + w] = 1'b1;
        set_fifo_ptr[idx] = (set_fifo_ptr[idx] + 1) & (ways - 1);
        mark_recent(base, ways, w);
        return r;
      end
    end
    if (ways == 1) begin
      w = 0;
    end else if (cur_policy == POL_FIFO) begin
      w = set_fifo_ptr[idx] & (ways - 1);
      set_fifo_ptr[idx] = (w + 1) & (ways - 1);
    end else if (cur_policy == POL_LRU) begin
      w = 0;
      best = 0;
      for (int unsigned i = 0; i < ways; i++) begin
        if (line_age[base + i] > best) begin
          best = line_age[base + i];
          w = i;
        end
      end
    end else begin
      lsb = lfsr_state[0];
      lfsr_state = lfsr_state >> 1;
      if (lsb) lfsr_state = lfsr_state ^ LFSR_MASK;
      w = lfsr_state & (ways - 1);
    end
    r.evicted = 1'b1;
    r.victim = line_tag[base + w];
    line_tag[base + w] = tag;
    mark_recent(base, ways, w);
    return r;
  endfunction

  // receiver: switches among stall patterns, long hold on request
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  int          hold_seen = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= (rx_cycle % 4 == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result beat, hit %0b evicted %0b victim %h",
                 $time, m_tuser[0], m_tuser[1], m_tdata);
        fail_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (m_tuser[0] !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_tuser[0]);
          fail_count++;
        end
        if (m_tuser[1] !== want.evicted) begin
          $display("%0t: evicted expected %0b actual %0b", $time, want.evicted, m_tuser[1]);
          fail_count++;
        end
        if (m_tdata !== want.victim) begin
          $display("%0t: victim_tag expected %h actual %h", $time, want.victim, m_tdata);
          fail_count++;
        end
      end
    end
  end

  task automatic send_addr(input logic [31:0] a);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= a;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_lookups.push_back(predict_lookup(a));
    burst_left--;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_OFFSET_BITS:  cur_offset_bits = data[4:0];
      REG_LINES_LOG2:   cur_lines_log2 = data[3:0];
      REG_ORGANIZATION: cur_org = data[1:0];
      REG_POLICY:       cur_policy = data[1:0];
      REG_RANDOM_SEED:  lfsr_state = (data == 16'd0) ? 16'd1 : data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] off, input logic [15:0] lines,
                            input logic [15:0] org, input logic [15:0] pol,
                            input logic [15:0] seed, input bit with_unused);
    write_reg(REG_OFFSET_BITS, off);
    write_reg(REG_LINES_LOG2, lines);
    write_reg(REG_ORGANIZATION, org);
    write_reg(REG_POLICY, pol);
    write_reg(REG_RANDOM_SEED, seed);
    if (with_unused) write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // reset geometry: direct mapped, 1024 lines, fifo
  task automatic test_default_direct();
    send_addr(32'h0000_0000);
    send_addr(32'h0000_0000);
    send_addr(32'h0000_0400);   // same set, evicts the zero tag
    send_addr(32'hFFFF_FFFF);
    send_addr(32'hFFFF_FBFF);
    drain();
  endtask

  // one set of four ways walked through fifo, lru and random replacement
  task automatic test_four_way_replacement();
    set_config(16'd2, 16'd2, 16'(ORG_FOUR_WAY), 16'(POL_FIFO), 16'h0001, 1'b0);
    send_addr(32'h0000_0010);
    send_addr(32'h0000_0020);
    send_addr(32'h0000_0030);
    send_addr(32'h0000_0040);
    send_addr(32'h0000_0013);
    send_addr(32'h0000_0050);
    drain();
    set_config(16'd2, 16'd2, 16'(ORG_FOUR_WAY), 16'(POL_LRU), 16'h0001, 1'b0);
    send_addr(32'h0000_0060);
    drain();
    // zero seed loads one
    set_config(16'd2, 16'd2, 16'(ORG_FOUR_WAY), 16'(POL_ALT_RANDOM), 16'h0000, 1'b0);
    send_addr(32'h0000_0070);
    drain();
    set_config(16'd2, 16'd2, 16'(ORG_ALT_FULL), 16'(POL_RANDOM), 16'hFFFF, 1'b0);
    send_addr(32'h0000_0080);
    drain();
  endtask

  task automatic test_small_geometries();
    // four-way with two lines: a single two-way set
    set_config(16'd0, 16'd1, 16'(ORG_FOUR_WAY), 16'(POL_FIFO), 16'h0001, 1'b1);
    send_addr(32'h1234_5678);
    drain();
    // line count above the maximum, widest offset
    set_config(16'd31, 16'd15, 16'(ORG_DIRECT), 16'(POL_LRU), 16'h0001, 1'b0);
    send_addr(32'h8000_0000);
    send_addr(32'h7FFF_FFFF);
    drain();
    set_config(16'd0, 16'd0, 16'(ORG_DIRECT), 16'(POL_FIFO), 16'h0001, 1'b0);
    send_addr(32'hA5A5_5A5A);
    drain();
  endtask

  task automatic test_full_assoc_max();
    set_config(16'd0, 16'd10, 16'(ORG_FULL), 16'(POL_FIFO), 16'h0001, 1'b0);
    send_addr(32'hDEAD_BEEF);
    send_addr(32'hDEAD_BEEF);
    send_addr(32'h0000_0000);
    drain();
  endtask

  task automatic randomize_setup();
    logic [15:0] off, lines, org, pol;
    off = 16'($urandom);
    off[4:0] = ($urandom_range(0, 9) < 6) ? 5'($urandom_range(0, 8)) : 5'($urandom_range(0, 31));
    org = 16'($urandom);
    org[1:0] = 2'($urandom_range(0, 3));
    pol = 16'($urandom);
    pol[1:0] = 2'($urandom_range(0, 3));
    lines = 16'($urandom);
    // keep the fully associative walk short
    lines[3:0] = (org[1:0] == ORG_DIRECT || org[1:0] == ORG_FOUR_WAY) ?
                 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 4));
    set_config(off, lines, org, pol, 16'($urandom), $urandom_range(0, 3) == 0);
  endtask

  // addresses crowded onto a few sets so hits and evictions both show up
  task automatic build_pool();
    int unsigned ways, sets, ibits, shift, pool_n, nsel;
    longint unsigned v;
    cache_shape(ways, sets, ibits);
    shift = cur_offset_bits + ibits;
    pool_n = ways * sets * 2;
    if (pool_n > 40) pool_n = 40;
    if (pool_n < 3) pool_n = 3;
    nsel = (sets < 4) ? sets : 4;
    addr_pool.delete();
    for (int unsigned i = 0; i < pool_n; i++) begin
      v = (longint'($urandom) << shift) |
          (longint'($urandom_range(0, nsel - 1)) << cur_offset_bits) |
          (longint'($urandom) & ((64'd1 << cur_offset_bits) - 1));
      addr_pool.push_back(v[31:0]);
    end
  endtask

  task automatic send_pool_items(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) send_addr($urandom);
      else send_addr(addr_pool[$urandom_range(0, addr_pool.size() - 1)]);
    end
  endtask

  task automatic test_random_traffic(input int unsigned n);
    randomize_setup();
    build_pool();
    send_pool_items(n);
    drain();
  endtask

  // receiver holds off while the sender keeps offering, the block backs up
  task automatic test_output_backpressure();
    hold_req++;
    send_pool_items(40);
    drain();
  endtask

  // sender stops until every outstanding result is back, then resumes
  task automatic test_sender_pause();
    send_pool_items(10);
    drain();
    send_pool_items(10);
    drain();
  endtask

  initial begin
    cur_offset_bits = 5'd0;
    cur_lines_log2 = 4'd10;
    cur_org = ORG_DIRECT;
    cur_policy = POL_FIFO;
    lfsr_state = 16'd1;
    for (int i = 0; i < LINES; i++) begin
      line_tag[i] = '0;
      line_valid[i] = 1'b0;
      line_age[i] = 0;
      set_fifo_ptr[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_direct();
    test_four_way_replacement();
    test_small_geometries();
    test_full_assoc_max();
    for (int p = 0; p < 7; p++) begin
      test_random_traffic(140);
      if (p == 2) test_output_backpressure();
      if (p == 4) test_sender_pause();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_lookups.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
